// ----- hw/rtl/mi3_pkg.sv -----
package mi3_pkg;

  // element format
  localparam int ELEM_W = 32;
  localparam int FRAC_W = 16;

  // exact intermediate widths
  localparam int ADJ_W  = 2 * ELEM_W + 1;      // signed cofactor
  localparam int PP_W   = 2 * ELEM_W + 1;      // determinant partial product
  localparam int DET_W  = 3 * ELEM_W + 2;      // signed determinant
  localparam int MAG_W  = 3 * ELEM_W;          // determinant magnitude
  localparam int N2_W   = ADJ_W - 1 + 2 * FRAC_W + 1; // twice the scaled numerator
  localparam int REM_W  = MAG_W + ELEM_W + 1;  // room for divisor shifted by ELEM_W+1
  localparam int Q2_W   = ELEM_W + 1;          // quotient with one extra rounding bit
  localparam int DIV_STG = ELEM_W + 1;         // one quotient bit per stage

  // cofactor operands: adj[i] = a[A]*a[B] - a[C]*a[D]
  localparam int COF_A [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int COF_B [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int COF_C [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int COF_D [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  typedef struct packed {
    logic signed [ELEM_W-1:0] m00;
    logic signed [ELEM_W-1:0] m01;
    logic signed [ELEM_W-1:0] m02;
    logic signed [ELEM_W-1:0] m10;
    logic signed [ELEM_W-1:0] m11;
    logic signed [ELEM_W-1:0] m12;
    logic signed [ELEM_W-1:0] m20;
    logic signed [ELEM_W-1:0] m21;
    logic signed [ELEM_W-1:0] m22;
  } mi3_in_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] r00;
    logic signed [ELEM_W-1:0] r01;
    logic signed [ELEM_W-1:0] r02;
    logic signed [ELEM_W-1:0] r10;
    logic signed [ELEM_W-1:0] r11;
    logic signed [ELEM_W-1:0] r12;
    logic signed [ELEM_W-1:0] r20;
    logic signed [ELEM_W-1:0] r21;
    logic signed [ELEM_W-1:0] r22;
    logic                     singular;
    logic                     saturated;
  } mi3_out_t;

endpackage

// ----- hw/rtl/mi3_div.sv -----
module mi3_div import mi3_pkg::*; (
  input  logic               clk_i,
  input  logic [DIV_STG-1:0] en_i,
  input  logic [N2_W-1:0]    n2_i,
  input  logic [MAG_W-1:0]   dmag_i,
  input  logic               neg_i,
  input  logic               big_i,
  output logic [Q2_W-1:0]    q2_o,
  output logic               neg_o,
  output logic               big_o
);

  logic [REM_W-1:0] rem_q [DIV_STG];
  logic [Q2_W-1:0]  quo_q [DIV_STG];
  logic [MAG_W-1:0] den_q [DIV_STG];
  logic             neg_q [DIV_STG];
  logic             big_q [DIV_STG];

  // restoring division, one quotient bit per stage, msb first
  for (genvar j = 0; j < DIV_STG; j++) begin : g_step
    logic [REM_W-1:0] rem_in;
    logic [Q2_W-1:0]  quo_in;
    logic [MAG_W-1:0] den_in;
    logic             neg_in;
    logic             big_in;
    logic [REM_W-1:0] dsh;
    logic [REM_W:0]   diff;
    logic             take;
    logic [Q2_W-1:0]  quo_nx;

    if (j == 0) begin : g_first
      assign rem_in = REM_W'(n2_i);
      assign quo_in = '0;
      assign den_in = dmag_i;
      assign neg_in = neg_i;
      assign big_in = big_i;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign quo_in = quo_q[j-1];
      assign den_in = den_q[j-1];
      assign neg_in = neg_q[j-1];
      assign big_in = big_q[j-1];
    end

    // trial subtract of the divisor at this bit weight
    assign dsh    = REM_W'(den_in) << (ELEM_W - j);
    assign diff   = {1'b0, rem_in} - {1'b0, dsh};
    assign take   = !diff[REM_W];
    assign quo_nx = quo_in | (Q2_W'(take) << (ELEM_W - j));

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        rem_q[j] <= take ? diff[REM_W-1:0] : rem_in;
        quo_q[j] <= quo_nx;
        den_q[j] <= den_in;
        neg_q[j] <= neg_in;
        big_q[j] <= big_in;
      end
    end
  end

  assign q2_o  = quo_q[DIV_STG-1];
  assign neg_o = neg_q[DIV_STG-1];
  assign big_o = big_q[DIV_STG-1];

endmodule

// ----- hw/rtl/matrix_inverse_3x3.sv -----
// channel | dir | handshake              | beat
// in      | in  | in_valid_i / in_stall_o | nine Q16.16 matrix elements
// out     | out | out_valid_o / out_stall_i | nine inverse elements, singular, saturated
//
// one beat enters per cycle while in_stall_o is low
// the divider gives one quotient bit per stage over 33 stages
// ahead of it sit 6 stages of products, cofactors and determinant, then one output register
// reset clears the valid bits only; the datapath holds no state between beats
// out_stall_i stalls only the valid stages behind it, so bubbles still fill
module matrix_inverse_3x3 import mi3_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  mi3_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output mi3_out_t out_data_o
);

  localparam int ST_DIV = 6;
  localparam int NSTG   = ST_DIV + DIV_STG + 1;
  localparam int ST_OUT = NSTG - 1;

  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] en;
  logic [NSTG-1:0] v_in;

  // a stage moves unless it and everything after it is full and stalled
  for (genvar k = 0; k < NSTG; k++) begin : g_en
    assign en[k] = !(out_stall_i && (&v_q[NSTG-1:k]));
  end

  assign in_stall_o = !en[0];
  assign v_in       = {v_q[NSTG-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (en[k]) v_q[k] <= v_in[k];
      end
    end
  end

  // unpack matrix
  logic signed [ELEM_W-1:0] a [9];
  assign a[0] = in_data_i.m00;
  assign a[1] = in_data_i.m01;
  assign a[2] = in_data_i.m02;
  assign a[3] = in_data_i.m10;
  assign a[4] = in_data_i.m11;
  assign a[5] = in_data_i.m12;
  assign a[6] = in_data_i.m20;
  assign a[7] = in_data_i.m21;
  assign a[8] = in_data_i.m22;

  // stage 1: cofactor products
  logic signed [2*ELEM_W-1:0] p1_q [9];
  logic signed [2*ELEM_W-1:0] p2_q [9];
  logic signed [ELEM_W-1:0]   a1_q [3];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int i = 0; i < 9; i++) begin
        p1_q[i] <= a[COF_A[i]] * a[COF_B[i]];
        p2_q[i] <= a[COF_C[i]] * a[COF_D[i]];
      end
      for (int t = 0; t < 3; t++) a1_q[t] <= a[t];
    end
  end

  // stage 2: adjugate entries
  logic signed [ADJ_W-1:0]  adj2_q [9];
  logic signed [ELEM_W-1:0] a2_q   [3];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int i = 0; i < 9; i++) adj2_q[i] <= ADJ_W'(p1_q[i]) - ADJ_W'(p2_q[i]);
      for (int t = 0; t < 3; t++) a2_q[t] <= a1_q[t];
    end
  end

  // stage 3: determinant partial products, low and high halves of the cofactor
  logic signed [PP_W-1:0]  lo_q   [3];
  logic signed [PP_W-1:0]  hi_q   [3];
  logic signed [ADJ_W-1:0] adj3_q [9];

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int t = 0; t < 3; t++) begin
        lo_q[t] <= a2_q[t] * $signed({1'b0, adj2_q[3*t][ELEM_W-1:0]});
        hi_q[t] <= a2_q[t] * $signed(adj2_q[3*t][ADJ_W-1:ELEM_W]);
      end
      adj3_q <= adj2_q;
    end
  end

  // stage 4: recombine halves
  logic signed [DET_W-1:0] term_q [3];
  logic signed [ADJ_W-1:0] adj4_q [9];

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int t = 0; t < 3; t++) begin
        term_q[t] <= (DET_W'(hi_q[t]) <<< ELEM_W) + DET_W'(lo_q[t]);
      end
      adj4_q <= adj3_q;
    end
  end

  // stage 5: determinant
  logic signed [DET_W-1:0] det_q;
  logic signed [ADJ_W-1:0] adj5_q [9];

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      det_q  <= term_q[0] + term_q[1] + term_q[2];
      adj5_q <= adj4_q;
    end
  end

  // stage 6: magnitudes, signs and overflow test ahead of the divider
  logic              det_neg;
  logic [DET_W-1:0]  det_abs;
  logic [MAG_W-1:0]  dmag;
  logic [REM_W-1:0]  dlim;
  logic [ADJ_W-1:0]  adj_abs [9];
  logic [N2_W-1:0]   n2      [9];
  logic              lneg    [9];
  logic              lbig    [9];

  always_comb begin
    det_neg = det_q[DET_W-1];
    det_abs = det_neg ? DET_W'(-det_q) : DET_W'(det_q);
    dmag    = det_abs[MAG_W-1:0];
    dlim    = REM_W'(dmag) << (ELEM_W + 1);
    for (int i = 0; i < 9; i++) begin
      adj_abs[i] = adj5_q[i][ADJ_W-1] ? ADJ_W'(-adj5_q[i]) : ADJ_W'(adj5_q[i]);
      n2[i]      = {adj_abs[i][ADJ_W-2:0], {(2*FRAC_W+1){1'b0}}};
      lneg[i]    = (adj5_q[i][ADJ_W-1] ^ det_neg) && (adj5_q[i] != '0);
      lbig[i]    = REM_W'(n2[i]) >= dlim;
    end
  end

  logic [N2_W-1:0]  n2_q   [9];
  logic [MAG_W-1:0] dmag_q;
  logic             neg6_q [9];
  logic             big6_q [9];
  logic             sing6_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      n2_q    <= n2;
      dmag_q  <= dmag;
      neg6_q  <= lneg;
      big6_q  <= lbig;
      sing6_q <= (det_q == '0);
    end
  end

  // divider lanes
  logic [Q2_W-1:0] q2   [9];
  logic            qneg [9];
  logic            qbig [9];

  for (genvar i = 0; i < 9; i++) begin : g_lane
    mi3_div u_div (
      .clk_i  (clk_i),
      .en_i   (en[ST_DIV +: DIV_STG]),
      .n2_i   (n2_q[i]),
      .dmag_i (dmag_q),
      .neg_i  (neg6_q[i]),
      .big_i  (big6_q[i]),
      .q2_o   (q2[i]),
      .neg_o  (qneg[i]),
      .big_o  (qbig[i])
    );
  end

  // singular flag rides alongside the divider
  logic sing_q [DIV_STG];

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < DIV_STG; j++) begin
      if (en[ST_DIV + j]) sing_q[j] <= (j == 0) ? sing6_q : sing_q[(j == 0) ? 0 : j - 1];
    end
  end

  // round, clip and encode
  logic [Q2_W:0]       q2_inc [9];
  logic [ELEM_W:0]     mag    [9];
  logic [ELEM_W:0]     limit  [9];
  logic [ELEM_W:0]     clipd  [9];
  logic                clip   [9];
  logic [ELEM_W-1:0]   res    [9];
  logic                any_clip;
  logic                sing_l;
  mi3_out_t            out_d;

  always_comb begin
    any_clip = 1'b0;
    sing_l   = sing_q[DIV_STG-1];
    for (int i = 0; i < 9; i++) begin
      q2_inc[i] = {1'b0, q2[i]} + (Q2_W+1)'(1);
      mag[i]    = q2_inc[i][Q2_W:1];
      limit[i]  = ((ELEM_W+1)'(1) << (ELEM_W - 1)) - (qneg[i] ? '0 : (ELEM_W+1)'(1));
      clip[i]   = qbig[i] || (mag[i] > limit[i]);
      clipd[i]  = clip[i] ? limit[i] : mag[i];
      res[i]    = qneg[i] ? ELEM_W'(-clipd[i]) : clipd[i][ELEM_W-1:0];
      if (sing_l) res[i] = '0;
      any_clip  = any_clip | clip[i];
    end
    out_d.r00       = res[0];
    out_d.r01       = res[1];
    out_d.r02       = res[2];
    out_d.r10       = res[3];
    out_d.r11       = res[4];
    out_d.r12       = res[5];
    out_d.r20       = res[6];
    out_d.r21       = res[7];
    out_d.r22       = res[8];
    out_d.singular  = sing_l;
    out_d.saturated = any_clip && !sing_l;
  end

  // output register
  mi3_out_t out_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) out_q <= out_d;
  end

  assign out_valid_o = v_q[ST_OUT];
  assign out_data_o  = out_q;

`ifndef SYNTH
  // input stalls only when the whole pipe is full behind a stalled output
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_stall_i && (&v_q)))
    else $error("input stalled with a bubble in the pipe");

  // a singular beat carries zero elements and no clip flag
  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.singular) |->
      (out_data_o.r00 == '0 && out_data_o.r01 == '0 && out_data_o.r02 == '0 &&
       out_data_o.r10 == '0 && out_data_o.r11 == '0 && out_data_o.r12 == '0 &&
       out_data_o.r20 == '0 && out_data_o.r21 == '0 && out_data_o.r22 == '0 &&
       !out_data_o.saturated))
    else $error("singular result with nonzero payload");

  // a full stalled output stage keeps its beat into the next cycle
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result lost or changed");
`endif

endmodule
